@@ rtl/core/ucd_pkg.sv @@
package ucd_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned CP_W    = 21;
	localparam int unsigned USED_W  = 3;
	localparam int unsigned AVAIL_W = 3;
	localparam int unsigned BITS_W  = 6;
	localparam int unsigned LEAD_W  = 7;
	localparam int unsigned NUM_LANES = 3;

	localparam logic [BYTE_W-1:0] CONT_LO = 8'b10000000;
	localparam logic [BYTE_W-1:0] CONT_HI = 8'b10111111;
	localparam logic [BYTE_W-1:0] E0_LO   = 8'hA0;
	localparam logic [BYTE_W-1:0] ED_HI   = 8'h9F;
	localparam logic [BYTE_W-1:0] F0_LO   = 8'h90;
	localparam logic [BYTE_W-1:0] F4_HI   = 8'h8F;
	localparam logic [BITS_W-1:0] CONT_PAYLOAD = 6'b111111;

	localparam logic [CP_W-1:0] REPLACEMENT = 21'h00FFFD;

	localparam logic [USED_W-1:0] LEN_0 = 3'd0;
	localparam logic [USED_W-1:0] LEN_1 = 3'd1;
	localparam logic [USED_W-1:0] LEN_2 = 3'd2;
	localparam logic [USED_W-1:0] LEN_3 = 3'd3;
	localparam logic [USED_W-1:0] LEN_4 = 3'd4;

	// lead byte classification
	typedef struct packed {
		logic               ascii;
		logic               invalid;
		logic [USED_W-1:0]  len;
		logic [BYTE_W-1:0]  lo;
		logic [BYTE_W-1:0]  hi;
		logic [LEAD_W-1:0]  bits;
	} lead_t;

	// everything the merge stage needs about one window
	typedef struct packed {
		logic                               empty;
		logic                               short_win;
		lead_t                              lead;
		logic [NUM_LANES-1:0]               lane_ok;
		logic [NUM_LANES-1:0][BITS_W-1:0]   lane_bits;
	} win_t;

endpackage

@@ rtl/core/ucd_lead.sv @@
module ucd_lead
	import ucd_pkg::*;
(
	input  logic [BYTE_W-1:0] byte0,
	output lead_t             lead
);

	always_comb begin
		lead.ascii   = 1'b0;
		lead.invalid = 1'b0;
		lead.len     = LEN_1;
		lead.lo      = CONT_LO;
		lead.hi      = CONT_HI;
		lead.bits    = byte0[LEAD_W-1:0];
		if (byte0 inside {[8'h00:8'h7F]}) begin
			lead.ascii = 1'b1;
		end else if (byte0 inside {[8'hC2:8'hDF]}) begin
			lead.len  = LEN_2;
			lead.bits = {2'b00, byte0[4:0]};
		end else if (byte0 inside {[8'hE0:8'hEF]}) begin
			lead.len  = LEN_3;
			lead.bits = {3'b000, byte0[3:0]};
			if (byte0 == 8'hE0) begin
				lead.lo = E0_LO;
			end else if (byte0 == 8'hED) begin
				lead.hi = ED_HI;
			end
		end else if (byte0 inside {[8'hF0:8'hF4]}) begin
			lead.len  = LEN_4;
			lead.bits = {4'b0000, byte0[2:0]};
			if (byte0 == 8'hF0) begin
				lead.lo = F0_LO;
			end else if (byte0 == 8'hF4) begin
				lead.hi = F4_HI;
			end
		end else begin
			lead.invalid = 1'b1;
		end
	end

endmodule

@@ rtl/core/ucd_lane.sv @@
module ucd_lane
	import ucd_pkg::*;
(
	input  logic [BYTE_W-1:0] data,
	input  logic [BYTE_W-1:0] lo,
	input  logic [BYTE_W-1:0] hi,
	output logic              ok,
	output logic [BITS_W-1:0] bits
);

	assign ok   = (data >= lo) && (data <= hi);
	assign bits = data[BITS_W-1:0] & CONT_PAYLOAD;

endmodule

@@ rtl/core/ucd_merge.sv @@
module ucd_merge
	import ucd_pkg::*;
(
	input  win_t              win,
	output logic [CP_W-1:0]   code_point,
	output logic [USED_W-1:0] used,
	output logic              bad
);

	logic              fail;
	logic [CP_W-1:0]   cp;

	always_comb begin
		fail = win.lead.invalid || win.short_win || !win.lane_ok[0]
			|| ((win.lead.len inside {LEN_3, LEN_4}) && !win.lane_ok[1])
			|| ((win.lead.len == LEN_4) && !win.lane_ok[2]);

		case (win.lead.len)
			LEN_2: cp = {10'd0, win.lead.bits[4:0], win.lane_bits[0]};
			LEN_3: cp = {5'd0, win.lead.bits[3:0], win.lane_bits[0], win.lane_bits[1]};
			LEN_4: cp = {win.lead.bits[2:0], win.lane_bits[0], win.lane_bits[1],
				win.lane_bits[2]};
			default: cp = {14'd0, win.lead.bits};
		endcase

		if (win.empty) begin
			code_point = REPLACEMENT;
			used       = LEN_0;
			bad        = 1'b0;
		end else if (win.lead.ascii) begin
			code_point = {14'd0, win.lead.bits};
			used       = LEN_1;
			bad        = 1'b0;
		end else if (fail) begin
			code_point = REPLACEMENT;
			used       = LEN_1;
			bad        = 1'b1;
		end else begin
			code_point = cp;
			used       = win.lead.len;
			bad        = 1'b0;
		end
	end

endmodule

@@ rtl/core/utf8_codepoint_decoder.sv @@
// Channel | Ports                                   | Handshake
// --------+-----------------------------------------+---------------------------
// request | byte0, byte1, byte2, byte3, avail       | start high, busy low
// result  | code_point, used, bad                   | done high for one cycle
//
// One request per cycle, sustained; busy never rises.
// The lead decode and the three byte lanes feed a register, then the merge feeds the output registers.
// Reset clears the two valid flags; payload registers are not reset.
// The receiver cannot stall, so nothing is ever held back.
module utf8_codepoint_decoder
	import ucd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [BYTE_W-1:0]  byte0,
	input  logic [BYTE_W-1:0]  byte1,
	input  logic [BYTE_W-1:0]  byte2,
	input  logic [BYTE_W-1:0]  byte3,
	input  logic [AVAIL_W-1:0] avail,
	output logic               done,
	output logic [CP_W-1:0]    code_point,
	output logic [USED_W-1:0]  used,
	output logic               bad
);

	lead_t                              lead;
	logic [NUM_LANES-1:0][BYTE_W-1:0]   lane_data;
	logic [NUM_LANES-1:0][BYTE_W-1:0]   lane_lo;
	logic [NUM_LANES-1:0][BYTE_W-1:0]   lane_hi;
	logic [NUM_LANES-1:0]               lane_ok;
	logic [NUM_LANES-1:0][BITS_W-1:0]   lane_bits;
	win_t                               win;

	win_t                               win_s1;
	logic                               valid_s1;

	logic [CP_W-1:0]                    m_code_point;
	logic [USED_W-1:0]                  m_used;
	logic                               m_bad;

	// the decoder takes a request every cycle
	assign busy = 1'b0;

	ucd_lead u_lead (
		.byte0 (byte0),
		.lead  (lead)
	);

	// the first continuation lane takes its bounds from the lead byte;
	// the other two always check the plain continuation range
	assign lane_data = {byte3, byte2, byte1};
	assign lane_lo   = {CONT_LO, CONT_LO, lead.lo};
	assign lane_hi   = {CONT_HI, CONT_HI, lead.hi};

	for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
		ucd_lane u_lane (
			.data (lane_data[g]),
			.lo   (lane_lo[g]),
			.hi   (lane_hi[g]),
			.ok   (lane_ok[g]),
			.bits (lane_bits[g])
		);
	end

	always_comb begin
		win.empty     = (avail == '0);
		win.short_win = (avail < lead.len);
		win.lead      = lead;
		win.lane_ok   = lane_ok;
		win.lane_bits = lane_bits;
	end

	// stage 1: hold the lane findings
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			win_s1 <= win;
		end
	end

	ucd_merge u_merge (
		.win        (win_s1),
		.code_point (m_code_point),
		.used       (m_used),
		.bad        (m_bad)
	);

	// stage 2: registered result with a one-cycle strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			code_point <= m_code_point;
			used       <= m_used;
			bad        <= m_bad;
		end
	end

endmodule

@@ bench/tb.sv @@
module tb;
	import ucd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// Lead byte boundaries of the encoding
	localparam logic [BYTE_W-1:0] ASCII_MAX = 8'h7F;
	localparam logic [BYTE_W-1:0] LEAD2_MIN = 8'hC2;
	localparam logic [BYTE_W-1:0] LEAD2_MAX = 8'hDF;
	localparam logic [BYTE_W-1:0] LEAD3_MIN = 8'hE0;
	localparam logic [BYTE_W-1:0] LEAD_ED   = 8'hED;
	localparam logic [BYTE_W-1:0] LEAD3_MAX = 8'hEF;
	localparam logic [BYTE_W-1:0] LEAD4_MIN = 8'hF0;
	localparam logic [BYTE_W-1:0] LEAD4_MAX = 8'hF4;
	localparam logic [AVAIL_W-1:0] AVAIL_MAX = 3'd7;

	localparam int RESET_CYCLES   = 12;
	localparam int DRAIN_CYCLES   = 10;   // pipeline is two deep; allow some slack
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_ITEMS    = 200;

	// One window as it goes onto the request ports
	typedef struct packed {
		logic [BYTE_W-1:0]  b0;
		logic [BYTE_W-1:0]  b1;
		logic [BYTE_W-1:0]  b2;
		logic [BYTE_W-1:0]  b3;
		logic [AVAIL_W-1:0] avail;
	} window_t;

	// A window waiting to be sent, with the chance (percent) that the sender
	// idles rather than offering it
	typedef struct {
		window_t     win;
		int unsigned idle_pct;
	} pending_t;

	// One decoded scalar as the result ports carry it
	typedef struct packed {
		logic [CP_W-1:0]   cp;
		logic [USED_W-1:0] used;
		logic              bad;
	} scalar_t;

	logic               clk    = 1'b0;
	logic               arst_n = 1'b0;
	logic               start  = 1'b0;
	logic [BYTE_W-1:0]  byte0  = '0;
	logic [BYTE_W-1:0]  byte1  = '0;
	logic [BYTE_W-1:0]  byte2  = '0;
	logic [BYTE_W-1:0]  byte3  = '0;
	logic [AVAIL_W-1:0] avail  = '0;
	logic               busy;
	logic               done;
	logic [CP_W-1:0]    code_point;
	logic [USED_W-1:0]  used;
	logic               bad;

	pending_t windows_to_send[$];
	scalar_t  cp_expected[$];
	int       mismatches   = 0;
	int       stall_cycles = 0;

	utf8_codepoint_decoder dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.byte0      (byte0),
		.byte1      (byte1),
		.byte2      (byte2),
		.byte3      (byte3),
		.avail      (avail),
		.done       (done),
		.code_point (code_point),
		.used       (used),
		.bad        (bad)
	);

	always #1 clk = ~clk;

	// Decode the first code point of a window. Any failure yields the
	// replacement character with one byte consumed and the error flag set.
	function automatic scalar_t decode_utf8(window_t w);
		scalar_t           r;
		logic [USED_W-1:0] seq_len;
		logic [BYTE_W-1:0] lo;
		logic [BYTE_W-1:0] hi;
		lo     = CONT_LO;
		hi     = CONT_HI;
		r.cp   = REPLACEMENT;
		r.used = LEN_1;
		r.bad  = 1'b1;
		// empty window: replacement, nothing consumed, not an error
		if (w.avail == LEN_0) begin
			r.used = LEN_0;
			r.bad  = 1'b0;
			return r;
		end
		if (w.b0 <= ASCII_MAX) begin
			r.cp  = {{(CP_W-BYTE_W){1'b0}}, w.b0};
			r.bad = 1'b0;
			return r;
		end
		// continuation bytes, overlong two-byte leads and leads past U+10FFFF
		if (w.b0 < LEAD2_MIN || w.b0 > LEAD4_MAX)
			return r;
		if (w.b0 <= LEAD2_MAX) begin
			seq_len = LEN_2;
		end else if (w.b0 <= LEAD3_MAX) begin
			seq_len = LEN_3;
			if (w.b0 == LEAD3_MIN)
				lo = E0_LO;
			else if (w.b0 == LEAD_ED)
				hi = ED_HI;
		end else begin
			seq_len = LEN_4;
			if (w.b0 == LEAD4_MIN)
				lo = F0_LO;
			else if (w.b0 == LEAD4_MAX)
				hi = F4_HI;
		end
		// avail of five or more compares as four here, which is what we want
		if (w.avail < seq_len || w.b1 < lo || w.b1 > hi)
			return r;
		if (seq_len >= LEN_3 && (w.b2 < CONT_LO || w.b2 > CONT_HI))
			return r;
		if (seq_len == LEN_4 && (w.b3 < CONT_LO || w.b3 > CONT_HI))
			return r;
		case (seq_len)
			LEN_2: r.cp = {10'd0, w.b0[4:0], w.b1[5:0]};
			LEN_3: r.cp = {5'd0, w.b0[3:0], w.b1[5:0], w.b2[5:0]};
			default: r.cp = {w.b0[2:0], w.b1[5:0], w.b2[5:0], w.b3[5:0]};
		endcase
		r.used = seq_len;
		r.bad  = 1'b0;
		return r;
	endfunction

	// Mostly well-formed sequences with random content, hitting the second-byte
	// bounds often; a quarter of all windows are picked to be broken, and a fifth
	// of all windows are pure noise.
	function automatic window_t random_window();
		window_t     w;
		int unsigned kind;
		int unsigned seq_len;
		logic [BYTE_W-1:0] lo;
		logic [BYTE_W-1:0] hi;
		w.b0    = BYTE_W'($urandom);
		w.b1    = BYTE_W'($urandom);
		w.b2    = BYTE_W'($urandom);
		w.b3    = BYTE_W'($urandom);
		w.avail = AVAIL_W'($urandom);
		kind    = $urandom_range(99);
		if (kind < 20)
			return w;
		seq_len = $urandom_range(4, 1);
		lo      = CONT_LO;
		hi      = CONT_HI;
		case (seq_len)
			1: w.b0 = BYTE_W'($urandom_range(ASCII_MAX, 0));
			2: w.b0 = BYTE_W'($urandom_range(LEAD2_MAX, LEAD2_MIN));
			3: begin
				if ($urandom_range(3) == 0)
					w.b0 = ($urandom_range(1) != 0) ? LEAD3_MIN : LEAD_ED;
				else
					w.b0 = BYTE_W'($urandom_range(LEAD3_MAX, LEAD3_MIN));
				if (w.b0 == LEAD3_MIN)
					lo = E0_LO;
				else if (w.b0 == LEAD_ED)
					hi = ED_HI;
			end
			default: begin
				w.b0 = BYTE_W'($urandom_range(LEAD4_MAX, LEAD4_MIN));
				if (w.b0 == LEAD4_MIN)
					lo = F0_LO;
				else if (w.b0 == LEAD4_MAX)
					hi = F4_HI;
			end
		endcase
		if ($urandom_range(3) == 0)
			w.b1 = ($urandom_range(1) != 0) ? lo : hi;
		else
			w.b1 = BYTE_W'($urandom_range(hi, lo));
		w.b2    = BYTE_W'($urandom_range(CONT_HI, CONT_LO));
		w.b3    = BYTE_W'($urandom_range(CONT_HI, CONT_LO));
		w.avail = AVAIL_W'($urandom_range(AVAIL_MAX, seq_len));
		if (kind >= 75) begin
			case ($urandom_range(3))
				0: if (seq_len > 1)
					w.avail = AVAIL_W'($urandom_range(seq_len - 1, 1));
				1: w.b1 = ($urandom_range(1) != 0) ? lo - 8'd1 : hi + 8'd1;
				2: w.b2 = BYTE_W'($urandom);
				default: w.b3 = BYTE_W'($urandom);
			endcase
		end
		return w;
	endfunction

	task automatic queue_window(input logic [BYTE_W-1:0] b0, input logic [BYTE_W-1:0] b1,
	                            input logic [BYTE_W-1:0] b2, input logic [BYTE_W-1:0] b3,
	                            input logic [AVAIL_W-1:0] n);
		pending_t p;
		p.win      = {b0, b1, b2, b3, n};
		p.idle_pct = 0;
		windows_to_send.push_back(p);
	endtask

	// Stimulus: directed corners first, then random phases with varying
	// sender idling. Hold reset, release it, then wait for the pipe to drain.
	initial begin
		pending_t p;
		int       phase;
		int       k;
		int unsigned phase_idle[3];
		phase_idle = '{0, 66, 34};

		// empty window, ASCII extremes, junk after a single byte
		queue_window(8'h41, 8'h42, 8'h43, 8'h44, 3'd0);
		queue_window(8'h00, 8'hFF, 8'hFF, 8'hFF, 3'd1);
		queue_window(8'h7F, 8'h80, 8'h80, 8'h80, 3'd4);
		// invalid leads: continuation bytes, overlong two-byte, above range
		queue_window(8'h80, 8'h80, 8'h80, 8'h80, 3'd4);
		queue_window(8'hC1, 8'hBF, 8'h80, 8'h80, 3'd4);
		queue_window(8'hF5, 8'h80, 8'h80, 8'h80, 3'd4);
		queue_window(8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd7);
		// two-byte extremes and a bad second byte
		queue_window(8'hC2, 8'h80, 8'h00, 8'h00, 3'd2);
		queue_window(8'hDF, 8'hBF, 8'hFF, 8'hFF, 3'd3);
		queue_window(8'hC3, 8'h28, 8'h80, 8'h80, 3'd4);
		// three-byte: overlong edge, surrogate edge, top, bad third byte
		queue_window(8'hE0, 8'hA0, 8'h80, 8'h00, 3'd3);
		queue_window(8'hE0, 8'h9F, 8'hBF, 8'h00, 3'd3);
		queue_window(8'hED, 8'h9F, 8'hBF, 8'h00, 3'd3);
		queue_window(8'hED, 8'hA0, 8'h80, 8'h00, 3'd3);
		queue_window(8'hEF, 8'hBF, 8'hBF, 8'hFF, 3'd4);
		queue_window(8'hE2, 8'h82, 8'h41, 8'h00, 3'd3);
		// short windows
		queue_window(8'hE2, 8'h82, 8'hAC, 8'h00, 3'd2);
		queue_window(8'hF0, 8'h9F, 8'h98, 8'h80, 3'd3);
		// four-byte: overlong edge, lowest, top, past U+10FFFF, bad fourth byte
		queue_window(8'hF0, 8'h8F, 8'hBF, 8'hBF, 3'd4);
		queue_window(8'hF0, 8'h90, 8'h80, 8'h80, 3'd4);
		queue_window(8'hF4, 8'h8F, 8'hBF, 8'hBF, 3'd5);
		queue_window(8'hF4, 8'h90, 8'h80, 8'h80, 3'd4);
		queue_window(8'hF1, 8'h80, 8'h80, 8'hC0, 3'd6);
		// large avail behaves as four
		queue_window(8'hF3, 8'hBF, 8'hBF, 8'hBF, 3'd7);

		for (phase = 0; phase < 3; phase++) begin
			for (k = 0; k < PHASE_ITEMS; k++) begin
				p.win      = random_window();
				p.idle_pct = phase_idle[phase];
				windows_to_send.push_back(p);
			end
		end

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// drain: nothing left to send, nothing on the ports, nothing in flight
		while (windows_to_send.size() != 0 || start || cp_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("[utf8_codepoint_decoder] OK");
		else
			$display("[utf8_codepoint_decoder] ERROR");
		$finish;
	end

	// Driver: book the request the block takes at this edge, then offer the
	// next window or idle. A request refused by busy holds on the ports.
	always @(posedge clk) begin
		pending_t nxt;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				cp_expected.push_back(decode_utf8({byte0, byte1, byte2, byte3, avail}));
			end
			if (!start || !busy) begin
				if (windows_to_send.size() != 0 &&
				    $urandom_range(99) >= windows_to_send[0].idle_pct) begin
					nxt = windows_to_send.pop_front();
					byte0 <= nxt.win.b0;
					byte1 <= nxt.win.b1;
					byte2 <= nxt.win.b2;
					byte3 <= nxt.win.b3;
					avail <= nxt.win.avail;
					start <= 1'b1;
				end else begin
					// drop start and toggle junk on the data ports while idle
					byte0 <= BYTE_W'($urandom);
					byte1 <= BYTE_W'($urandom);
					byte2 <= BYTE_W'($urandom);
					byte3 <= BYTE_W'($urandom);
					avail <= AVAIL_W'($urandom);
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: the receiver cannot stall, so take every done strobe and
	// match it against the oldest outstanding request.
	always @(posedge clk) begin
		scalar_t want;
		if (arst_n && done) begin
			if (cp_expected.size() == 0) begin
				$error("result with no request outstanding: code_point %h used %0d bad %b",
				       code_point, used, bad);
				mismatches++;
			end else begin
				want = cp_expected.pop_front();
				if (code_point !== want.cp) begin
					$error("code_point expected %h actual %h", want.cp, code_point);
					mismatches++;
				end
				if (used !== want.used) begin
					$error("used expected %0d actual %0d", want.used, used);
					mismatches++;
				end
				if (bad !== want.bad) begin
					$error("bad expected %b actual %b", want.bad, bad);
					mismatches++;
				end
			end
		end
	end

	// Watchdog: advance on cycles where neither a request nor a result moves
	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("[utf8_codepoint_decoder] ERROR");
				$finish;
			end
		end
	end

endmodule

@@ utf8_codepoint_decoder.f @@
rtl/core/ucd_pkg.sv
rtl/core/ucd_lead.sv
rtl/core/ucd_lane.sv
rtl/core/ucd_merge.sv
rtl/core/utf8_codepoint_decoder.sv
bench/tb.sv
